// ===== hdl/seed_rectangle_dilation_map_assert.svh =====
// Assertion macros shared by the seed rectangle dilation map checker.
// No dependencies; taken in by `include.
`ifndef SEED_RECTANGLE_DILATION_MAP_ASSERT_SVH
`define SEED_RECTANGLE_DILATION_MAP_ASSERT_SVH

// Same-cycle implication, reset disables the check.
`define SRDM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset disables the check.
`define SRDM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srdm_pkg.sv =====
// Shared types and constants of the seed rectangle dilation map.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package srdm_pkg;

  // Parameter defaults
  localparam int unsigned MAX_ROWS_DEF = 64;
  localparam int unsigned MAX_COLS_DEF = 64;

  // Fixed field widths
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned SEED_W     = 12;
  localparam int unsigned CSEL_W     = 6;
  localparam int unsigned BITS_W     = 64;
  localparam int unsigned ROWS_REG_W = 7;
  localparam int unsigned COLS_REG_W = 7;
  localparam int unsigned HALF_W     = 6;

  // Configuration port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_MARK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_e;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_HALF_HEIGHT = 2'd2,
    REG_HALF_WIDTH  = 2'd3
  } reg_index_e;

  // Map memory control
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctrl_t;

endpackage

// ===== hdl/srdm_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle on a shared
// subtract/compare unit. Depends on srdm_pkg.
`timescale 1ns / 1ps

module srdm_divider #(
  parameter int unsigned DIV_W = 7
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [srdm_pkg::SEED_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]            divisor_i,
  output logic                        done_o,
  output logic [srdm_pkg::SEED_W-1:0] quotient_o,
  output logic [DIV_W-1:0]            remainder_o
);

  localparam int unsigned SW  = srdm_pkg::SEED_W;
  localparam int unsigned CNT = $clog2(SW + 1);

  logic [SW-1:0]    quo_q, quo_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [CNT-1:0]   cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // Shared unit: shift in next dividend bit, trial subtract
  assign trial = {rem_q, quo_q[SW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = ~diff[DIV_W];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT'(SW);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[SW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hdl/srdm_map_mem.sv =====
// Single-port mark map memory, one word per column, registered read.
// Depends on srdm_pkg for the control struct.
`timescale 1ns / 1ps

module srdm_map_mem #(
  parameter int unsigned WORD_W = 64,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned AW     = 6
) (
  input  logic                clk_i,
  input  srdm_pkg::mem_ctrl_t ctrl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [WORD_W-1:0]   wdata_i,
  output logic [WORD_W-1:0]   rdata_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/seed_rectangle_dilation_map.sv =====
// Top level of the seed rectangle dilation map: APB registers, sequencer.
// Depends on srdm_pkg, srdm_divider and srdm_map_mem.
`timescale 1ns / 1ps

// Keeps a binary mark map of MAX_COLS column words (bit r = row r). A request
// is taken when start is high and busy is low; its one result appears on
// column_bits_o/status_o for exactly one cycle with done_o high and cannot be
// held off. A mark first splits the seed into row and column on the
// one-bit-per-cycle divider, then reads and writes each clipped column (at
// most 2*half_width of them) through the single memory port. A seed beyond the
// image answers after the division. A clear zeroes one column per cycle.
// After reset the map is cleared in a pass with busy high; register writes
// are taken anytime.
module seed_rectangle_dilation_map #(
  parameter int unsigned MAX_ROWS = srdm_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS = srdm_pkg::MAX_COLS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [srdm_pkg::REQ_W-1:0]    req_type_i,
  input  logic [srdm_pkg::SEED_W-1:0]   seed_index_i,
  input  logic [srdm_pkg::CSEL_W-1:0]   column_select_i,
  // result channel
  output logic                          done_o,
  output logic [srdm_pkg::BITS_W-1:0]   column_bits_o,
  output logic                          status_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srdm_pkg::APB_AW-1:0]   paddr,
  input  logic [srdm_pkg::APB_DW-1:0]   pwdata,
  output logic [srdm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned RW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNW = $clog2(MAX_COLS + 1);
  localparam int unsigned AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned XW  = srdm_pkg::SEED_W + 2;
  localparam int unsigned YW  = RW + 7;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_COL   = 6'b001000,
    ST_WR    = 6'b010000,
    ST_RDC   = 6'b100000
  } state_e;

  // ---------------- configuration registers ----------------
  logic [srdm_pkg::ROWS_REG_W-1:0] image_rows_q;
  logic [srdm_pkg::COLS_REG_W-1:0] image_cols_q;
  logic [srdm_pkg::HALF_W-1:0]     half_height_q;
  logic [srdm_pkg::HALF_W-1:0]     half_width_q;
  logic                            cfg_wr;
  srdm_pkg::reg_index_e            cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign cfg_idx = srdm_pkg::reg_index_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= srdm_pkg::ROWS_REG_W'(64);
      image_cols_q  <= srdm_pkg::COLS_REG_W'(64);
      half_height_q <= srdm_pkg::HALF_W'(1);
      half_width_q  <= srdm_pkg::HALF_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        srdm_pkg::REG_IMAGE_ROWS:  image_rows_q  <= pwdata[srdm_pkg::ROWS_REG_W-1:0];
        srdm_pkg::REG_IMAGE_COLS:  image_cols_q  <= pwdata[srdm_pkg::COLS_REG_W-1:0];
        srdm_pkg::REG_HALF_HEIGHT: half_height_q <= pwdata[srdm_pkg::HALF_W-1:0];
        srdm_pkg::REG_HALF_WIDTH:  half_width_q  <= pwdata[srdm_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      srdm_pkg::REG_IMAGE_ROWS:  prdata = srdm_pkg::APB_DW'(image_rows_q);
      srdm_pkg::REG_IMAGE_COLS:  prdata = srdm_pkg::APB_DW'(image_cols_q);
      srdm_pkg::REG_HALF_HEIGHT: prdata = srdm_pkg::APB_DW'(half_height_q);
      srdm_pkg::REG_HALF_WIDTH:  prdata = srdm_pkg::APB_DW'(half_width_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- effective image size ----------------
  logic [RW-1:0]  rows_eff;
  logic [CNW-1:0] cols_eff;

  always_comb begin
    if (image_rows_q == '0) begin
      rows_eff = RW'(1);
    end else if (int'(image_rows_q) > int'(MAX_ROWS)) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(image_rows_q);
    end
    if (image_cols_q == '0) begin
      cols_eff = CNW'(1);
    end else if (int'(image_cols_q) > int'(MAX_COLS)) begin
      cols_eff = CNW'(MAX_COLS);
    end else begin
      cols_eff = CNW'(image_cols_q);
    end
  end

  // ---------------- divider: seed -> column, row ----------------
  logic                        div_start;
  logic                        div_done;
  logic [srdm_pkg::SEED_W-1:0] div_quo;
  logic [RW-1:0]               div_rem;

  srdm_divider #(
    .DIV_W (RW)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (seed_index_i),
    .divisor_i   (rows_eff),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // ---------------- window bounds from quotient and remainder ----------------
  logic [XW-1:0]       quo_x, cols_x, hw_x, c0_x, csum_x, c1_x;
  logic [YW-1:0]       row_y, rows_y, hh_y, r0_y, rsum_y, r1_y;
  logic [RW-1:0]       r0, r1;
  logic                col_ovf;
  logic [MAX_ROWS-1:0] mask_new;

  always_comb begin
    quo_x   = XW'(div_quo);
    cols_x  = XW'(cols_eff);
    hw_x    = XW'(half_width_q);
    col_ovf = quo_x >= cols_x;
    c0_x    = (quo_x > hw_x) ? (quo_x - hw_x) : '0;
    csum_x  = quo_x + hw_x;
    c1_x    = (csum_x < cols_x) ? csum_x : cols_x;

    row_y  = YW'(div_rem);
    rows_y = YW'(rows_eff);
    hh_y   = YW'(half_height_q);
    r0_y   = (row_y > hh_y) ? (row_y - hh_y) : '0;
    rsum_y = row_y + hh_y;
    r1_y   = (rsum_y < rows_y) ? rsum_y : rows_y;
    r0     = RW'(r0_y);
    r1     = RW'(r1_y);
  end

  // Row mask [r0, r1)
  always_comb begin
    for (int i = 0; i < int'(MAX_ROWS); i++) begin
      mask_new[i] = (RW'(i) >= r0) && (RW'(i) < r1);
    end
  end

  // ---------------- map memory ----------------
  srdm_pkg::mem_ctrl_t mem_ctrl;
  logic [AW-1:0]       mem_addr;
  logic [MAX_ROWS-1:0] mem_wdata;
  logic [MAX_ROWS-1:0] mem_rdata;

  srdm_map_mem #(
    .WORD_W (MAX_ROWS),
    .DEPTH  (MAX_COLS),
    .AW     (AW)
  ) u_map_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // ---------------- sequencer ----------------
  state_e                      state_q, state_d;
  logic [CNW-1:0]              p_q, p_d;
  logic [CNW-1:0]              c1_q, c1_d;
  logic [MAX_ROWS-1:0]         mask_q, mask_d;
  logic                        clr_reply_q, clr_reply_d;
  logic                        done_q, done_d;
  logic [srdm_pkg::BITS_W-1:0] bits_q, bits_d;
  logic                        status_q, status_d;
  logic                        csel_ok;

  assign csel_ok = int'(column_select_i) < int'(MAX_COLS);

  always_comb begin
    state_d     = state_q;
    p_d         = p_q;
    c1_d        = c1_q;
    mask_d      = mask_q;
    clr_reply_d = clr_reply_q;
    done_d      = 1'b0;
    bits_d      = bits_q;
    status_d    = status_q;
    mem_ctrl    = '0;
    mem_addr    = p_q[AW-1:0];
    mem_wdata   = mem_rdata | mask_q;
    div_start   = 1'b0;

    unique case (state_q)
      // Zero one column per cycle
      ST_CLEAR: begin
        mem_ctrl.we = 1'b1;
        mem_wdata   = '0;
        p_d         = p_q + 1'b1;
        if (p_q == CNW'(MAX_COLS - 1)) begin
          p_d     = '0;
          state_d = ST_IDLE;
          if (clr_reply_q) begin
            clr_reply_d = 1'b0;
            done_d      = 1'b1;
            bits_d      = '0;
            status_d    = 1'b0;
          end
        end
      end

      // Take a request
      ST_IDLE: begin
        if (start) begin
          case (srdm_pkg::req_type_e'(req_type_i))
            srdm_pkg::REQ_MARK: begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
            srdm_pkg::REQ_READ: begin
              if (csel_ok) begin
                mem_ctrl.re = 1'b1;
                mem_addr    = AW'(column_select_i);
                state_d     = ST_RDC;
              end else begin
                done_d   = 1'b1;
                bits_d   = '0;
                status_d = 1'b0;
              end
            end
            srdm_pkg::REQ_CLEAR: begin
              p_d         = '0;
              clr_reply_d = 1'b1;
              state_d     = ST_CLEAR;
            end
            default: begin
              done_d   = 1'b1;
              bits_d   = '0;
              status_d = 1'b0;
            end
          endcase
        end
      end

      // Wait for the division, then answer a seed beyond the image or latch the window
      ST_DIV: begin
        if (div_done) begin
          if (col_ovf) begin
            done_d   = 1'b1;
            bits_d   = '0;
            status_d = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            p_d     = CNW'(c0_x);
            c1_d    = CNW'(c1_x);
            mask_d  = mask_new;
            state_d = ST_COL;
          end
        end
      end

      // Read the next column or finish
      ST_COL: begin
        if (p_q < c1_q) begin
          mem_ctrl.re = 1'b1;
          state_d     = ST_WR;
        end else begin
          done_d   = 1'b1;
          bits_d   = '0;
          status_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end

      // OR the mask into the column
      ST_WR: begin
        mem_ctrl.we = 1'b1;
        p_d         = p_q + 1'b1;
        state_d     = ST_COL;
      end

      // Return the column word
      ST_RDC: begin
        done_d   = 1'b1;
        bits_d   = srdm_pkg::BITS_W'(mem_rdata);
        status_d = 1'b0;
        state_d  = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      p_q         <= '0;
      clr_reply_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      clr_reply_q <= clr_reply_d;
      done_q      <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    c1_q     <= c1_d;
    mask_q   <= mask_d;
    bits_q   <= bits_d;
    status_q <= status_d;
  end

  assign busy          = state_q != ST_IDLE;
  assign done_o        = done_q;
  assign column_bits_o = bits_q;
  assign status_o      = status_q;

endmodule

// ===== hdl/srdm_checker.sv =====
// Port-level checker for the seed rectangle dilation map, bound to the top.
// Depends on srdm_pkg and seed_rectangle_dilation_map_assert.svh.
`timescale 1ns / 1ps

`include "seed_rectangle_dilation_map_assert.svh"

module srdm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        done_o,
  input logic [srdm_pkg::BITS_W-1:0] column_bits_o,
  input logic                        status_o
);

  logic accept;
  logic pend_q, pend_d;

  assign accept = start & ~busy;

  // One item in flight until its result is shown
  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (done_o) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SRDM_ASSERT_IMP(a_status_zero_bits, clk_i, rst_ni, done_o && status_o, column_bits_o == '0, "flagged seed returned nonzero bits")
  `SRDM_ASSERT_NXT(a_accept_progress, clk_i, rst_ni, accept, busy || done_o, "accepted item neither busy nor answered")
  `SRDM_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, done_o, pend_q, "result without an accepted item")
  `SRDM_ASSERT_IMP(a_no_lost, clk_i, rst_ni, pend_q && !busy, done_o, "item left idle without a result")

endmodule

bind seed_rectangle_dilation_map srdm_checker u_srdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .column_bits_o (column_bits_o),
  .status_o      (status_o)
);

// ===== tb/sv/dilation_map_checker.sv =====
`timescale 1ns / 1ps
// Checker for the seed rectangle dilation map: tracks register writes and requests,
// predicts each answer from its own copy of the mark map, and compares on done.
// Depends on srdm_pkg.

module dilation_map_checker
  import srdm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [SEED_W-1:0]     seed_index_i,
  input  logic [CSEL_W-1:0]     column_select_i,
  // result channel
  input  logic                  done_i,
  input  logic [BITS_W-1:0]     column_bits_i,
  input  logic                  status_i,
  // configuration port
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_AW-1:0]     paddr_i,
  input  logic [APB_DW-1:0]     pwdata_i,
  // status toward the bench top
  output int                    pending_o,
  output int                    fail_count_o,
  output int                    checked_o
);

  localparam int unsigned MAP_ROWS = MAX_ROWS_DEF;
  localparam int unsigned MAP_COLS = MAX_COLS_DEF;

  typedef struct packed {
    logic [BITS_W-1:0] column_bits;
    logic              status;
  } answer_t;

  // Predicted block state
  logic [BITS_W-1:0]     marks [MAP_COLS];
  logic [ROWS_REG_W-1:0] rows_reg;
  logic [COLS_REG_W-1:0] cols_reg;
  logic [HALF_W-1:0]     half_h_reg;
  logic [HALF_W-1:0]     half_w_reg;
  answer_t               answers_due [$];

  // Out-of-range sizes fall back to 1 or to the maximum
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // ones in bits [0, n)
  function automatic logic [BITS_W-1:0] low_ones(int unsigned n);
    if (n >= BITS_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Applies one request to the predicted map and returns its answer
  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [SEED_W-1:0] seed,
                               input logic [CSEL_W-1:0] csel, output answer_t ans);
    int unsigned rows, cols, row, col, r0, r1, c0, c1, p;
    logic [BITS_W-1:0] mask;
    ans = '0;
    case (req)
      REQ_MARK: begin
        rows = clamp_size(rows_reg, MAP_ROWS);
        cols = clamp_size(cols_reg, MAP_COLS);
        if (seed >= rows * cols) begin
          ans.status = 1'b1;
        end else begin
          row = seed % rows;
          col = seed / rows;
          r0  = (row > half_h_reg) ? row - half_h_reg : 0;
          r1  = (row + half_h_reg < rows) ? row + half_h_reg : rows;
          c0  = (col > half_w_reg) ? col - half_w_reg : 0;
          c1  = (col + half_w_reg < cols) ? col + half_w_reg : cols;
          // upper bounds are exclusive; a zero half size marks nothing
          if (r1 > r0) begin
            mask = low_ones(r1) & ~low_ones(r0);
            for (p = c0; p < c1; p++) marks[p] |= mask;
          end
        end
      end
      REQ_READ: begin
        if (csel < MAP_COLS) ans.column_bits = marks[csel];
      end
      REQ_CLEAR: begin
        for (p = 0; p < MAP_COLS; p++) marks[p] = '0;
      end
      default: ;
    endcase
  endtask

  // Register writes, result checks, then new requests, all at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t got, want, fresh;
    if (!rst_ni) begin
      foreach (marks[p]) marks[p] = '0;
      rows_reg     = 7'd64;
      cols_reg     = 7'd64;
      half_h_reg   = 6'd1;
      half_w_reg   = 6'd1;
      answers_due.delete();
      pending_o    = 0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_index_e'(paddr_i[APB_AW-1:2]))
          REG_IMAGE_ROWS:  rows_reg   = pwdata_i[ROWS_REG_W-1:0];
          REG_IMAGE_COLS:  cols_reg   = pwdata_i[COLS_REG_W-1:0];
          REG_HALF_HEIGHT: half_h_reg = pwdata_i[HALF_W-1:0];
          REG_HALF_WIDTH:  half_w_reg = pwdata_i[HALF_W-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        got.column_bits = column_bits_i;
        got.status      = status_i;
        if (answers_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: result with no request pending: expected none, actual bits %h status %b",
                   $time, got.column_bits, got.status);
        end else begin
          want = answers_due.pop_front();
          checked_o++;
          if (got.column_bits !== want.column_bits) begin
            fail_count_o++;
            $display("%0t: column_bits mismatch: expected %h, actual %h",
                     $time, want.column_bits, got.column_bits);
          end
          if (got.status !== want.status) begin
            fail_count_o++;
            $display("%0t: status mismatch: expected %b, actual %b",
                     $time, want.status, got.status);
          end
        end
      end
      if (start_i && !busy_i) begin
        apply_request(req_type_i, seed_index_i, column_select_i, fresh);
        answers_due.push_back(fresh);
      end
      pending_o = answers_due.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Bench top for the seed rectangle dilation map: clock, reset, APB setup and request stimulus.
// Depends on srdm_pkg, seed_rectangle_dilation_map and dilation_map_checker.

module testbench;
  import srdm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned      MAP_ROWS   = MAX_ROWS_DEF;
  localparam int unsigned      MAP_COLS   = MAX_COLS_DEF;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [REQ_W-1:0]    req_type      = '0;
  logic [SEED_W-1:0]   seed_index    = '0;
  logic [CSEL_W-1:0]   column_select = '0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic                busy;
  logic                done;
  logic [BITS_W-1:0]   column_bits;
  logic                status;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int          pending, fails, checked;
  int unsigned idle_pct = 0;
  int unsigned eff_rows = MAP_ROWS;
  int unsigned eff_cols = MAP_COLS;
  int unsigned n_mark, n_beyond, n_read, n_clear, n_unused, n_cfg;
  int unsigned idle_plan [4] = '{0, 85, 0, 13};

  seed_rectangle_dilation_map uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type),
    .seed_index_i    (seed_index),
    .column_select_i (column_select),
    .done_o          (done),
    .column_bits_o   (column_bits),
    .status_o        (status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  dilation_map_checker map_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .req_type_i      (req_type),
    .seed_index_i    (seed_index),
    .column_select_i (column_select),
    .done_i          (done),
    .column_bits_i   (column_bits),
    .status_i        (status),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pending_o       (pending),
    .fail_count_o    (fails),
    .checked_o       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Wait until every issued request has answered
  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // One item on the request channel, with random idle cycles ahead of it
  task automatic send_req(input logic [REQ_W-1:0] req, input logic [SEED_W-1:0] seed,
                          input logic [CSEL_W-1:0] csel);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    req_type      = req;
    seed_index    = seed;
    column_select = csel;
    start         = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    case (req)
      REQ_MARK: begin
        n_mark++;
        if (seed >= eff_rows * eff_cols) n_beyond++;
      end
      REQ_READ:  n_read++;
      REQ_CLEAR: n_clear++;
      default:   n_unused++;
    endcase
  endtask

  // APB write: setup cycle, then access cycle; unused data bits carry noise
  task automatic write_reg(input reg_index_e idx, input int unsigned val);
    logic [APB_DW-1:0] mask;
    mask = (idx == REG_IMAGE_ROWS || idx == REG_IMAGE_COLS) ? 32'h7F : 32'h3F;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = (APB_DW'($urandom) & ~mask) | (val & mask);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    n_cfg++;
  endtask

  task automatic configure(input int unsigned rows, input int unsigned cols,
                           input int unsigned hh, input int unsigned hw);
    drain();
    write_reg(REG_IMAGE_ROWS, rows);
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_HALF_WIDTH, hw);
    eff_rows = (rows == 0) ? 1 : (rows > MAP_ROWS) ? MAP_ROWS : rows;
    eff_cols = (cols == 0) ? 1 : (cols > MAP_COLS) ? MAP_COLS : cols;
  endtask

  // Random requests under one setting: mostly in-image seeds and in-image columns
  task automatic run_phase(input int unsigned rows, input int unsigned cols,
                           input int unsigned hh, input int unsigned hw,
                           input int unsigned idle, input int unsigned n);
    int unsigned       pick;
    logic [REQ_W-1:0]  req;
    logic [SEED_W-1:0] seed;
    logic [CSEL_W-1:0] csel;
    configure(rows, cols, hh, hw);
    idle_pct = idle;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 50)      req = REQ_MARK;
      else if (pick < 93) req = REQ_READ;
      else if (pick < 97) req = REQ_CLEAR;
      else                req = REQ_UNUSED;
      if ($urandom_range(9) < 8) seed = SEED_W'($urandom_range(eff_rows * eff_cols - 1));
      else                       seed = SEED_W'($urandom_range(4095));
      if ($urandom_range(9) < 7) csel = CSEL_W'($urandom_range(eff_cols - 1));
      else                       csel = CSEL_W'($urandom_range(63));
      // occasionally hold off until the block has answered everything
      if ($urandom_range(99) < 2) drain();
      send_req(req, seed, csel);
    end
    idle_pct = 0;
  endtask

  initial begin : stimulus
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed at reset settings: corner and interior marks, reads, an unused code, a clear
    send_req(REQ_MARK, 12'd0, 6'd0);
    send_req(REQ_MARK, 12'd4095, 6'd0);
    send_req(REQ_MARK, 12'd670, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd63);
    send_req(REQ_READ, 12'd0, 6'd10);
    send_req(REQ_READ, 12'd0, 6'd9);
    send_req(REQ_READ, 12'd0, 6'd11);
    send_req(REQ_READ, 12'd0, 6'd62);
    send_req(REQ_UNUSED, 12'd4095, 6'd63);
    send_req(REQ_READ, 12'd4095, 6'd63);
    send_req(REQ_CLEAR, 12'd0, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd63);
    // Small image: empty window, then seeds at and beyond the image size
    configure(5, 3, 0, 1);
    send_req(REQ_MARK, 12'd7, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd1);
    configure(5, 3, 2, 1);
    send_req(REQ_MARK, 12'd15, 6'd0);
    send_req(REQ_MARK, 12'd4095, 6'd0);
    send_req(REQ_MARK, 12'd14, 6'd0);
    send_req(REQ_READ, 12'd0, 6'd1);
    send_req(REQ_READ, 12'd0, 6'd2);
    send_req(REQ_READ, 12'd0, 6'd63);

    // Fixed settings at the extremes, including out-of-range sizes
    run_phase(64, 64, 63, 63, 0, 150);
    run_phase(1, 1, 0, 0, 85, 100);
    run_phase(0, 0, 3, 2, 0, 80);
    run_phase(127, 100, 2, 3, 13, 200);
    run_phase(64, 64, 0, 5, 85, 100);
    // Random settings; shrinking images leave stale marks to read back
    for (k = 0; k < 8; k++) begin
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(6),
                $urandom_range(6), idle_plan[k % 4], 120);
    end

    drain();
    repeat (200) @(negedge clk);
    $display("summary: %0d requests: %0d marks (%0d outside the image), %0d reads,",
             n_mark + n_read + n_clear + n_unused, n_mark, n_beyond, n_read);
    $display("summary: %0d clears, %0d unused codes, %0d register writes, %0d answers compared",
             n_clear, n_unused, n_cfg, checked);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/srdm_pkg.sv
hdl/srdm_divider.sv
hdl/srdm_map_mem.sv
hdl/seed_rectangle_dilation_map.sv
hdl/srdm_checker.sv
tb/sv/dilation_map_checker.sv
tb/sv/testbench.sv
